// File: rtl/core/plcl_pkg.sv
// ----------------------------------------------------------------------------
// plcl_pkg
// Shared types and constants for the piecewise linear color lookup core.
// ----------------------------------------------------------------------------
package plcl_pkg;

    // table geometry
    localparam int MAX_ENTRIES   = 64;
    localparam int KEY_BITS      = 12;
    localparam int ADDR_BITS     = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS      = ADDR_BITS + 1;
    localparam int INDEX_BITS    = 6;
    localparam int COUNT_BITS    = 7;
    localparam int CHAN_BITS     = 8;
    localparam int NUM_CHAN      = 4;
    localparam int CHAN_SEL_BITS = $clog2(NUM_CHAN);
    localparam int DIVIDEND_BITS = KEY_BITS + CHAN_BITS;

    localparam logic [COUNT_BITS-1:0] ENTRIES_RESET = COUNT_BITS'(40);

    typedef enum logic
    {
        CMD_WRITE  = 1'b0,
        CMD_LOOKUP = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        MATCH_NONE,
        MATCH_EXACT,
        MATCH_INTERP
    } match_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    // one breakpoint: key plus red, green, blue, alpha (index 0 is red)
    typedef struct packed
    {
        logic [KEY_BITS-1:0]                 key;
        logic [NUM_CHAN-1:0][CHAN_BITS-1:0]  chan;
    } entry_t;

    typedef struct packed
    {
        logic                      start;
        logic [DIVIDEND_BITS-1:0]  dividend;
        logic [KEY_BITS-1:0]       divisor;
    } div_req_t;

    typedef struct packed
    {
        logic                      done;
        logic [DIVIDEND_BITS-1:0]  quotient;
        logic                      rem_nz;
    } div_resp_t;

endpackage

// File: rtl/core/plcl_table.sv
// ----------------------------------------------------------------------------
// plcl_table
// Breakpoint memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module plcl_table
    import plcl_pkg::*;
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_BITS-1:0]  wr_addr,
    input  entry_t                wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_BITS-1:0]  rd_addr,
    output entry_t                rd_data
);

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/plcl_div.sv
// ----------------------------------------------------------------------------
// plcl_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plcl_div
    import plcl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  div_req_t   req,
    output div_resp_t  resp
);

    localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [KEY_BITS-1:0]       rem_reg, rem_next;
    logic [DIVIDEND_BITS-1:0]  quo_reg, quo_next;
    logic [KEY_BITS-1:0]       dvs_reg, dvs_next;
    logic [STEP_BITS-1:0]      cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [KEY_BITS:0]         trial;
    logic [KEY_BITS:0]         diff;

    // one shift-subtract step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = STEP_BITS'(DIVIDEND_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[KEY_BITS-1:0];
                quo_next = {quo_reg[DIVIDEND_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[KEY_BITS-1:0];
                quo_next = {quo_reg[DIVIDEND_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - STEP_BITS'(1);
            if (cnt_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign resp.done     = done_reg;
    assign resp.quotient = quo_reg;
    assign resp.rem_nz   = |rem_reg;

endmodule

// File: rtl/core/piecewise_linear_color_lookup_core.sv
// ----------------------------------------------------------------------------
// piecewise_linear_color_lookup_core
// Breakpoint table with per-channel linear interpolation between entries.
// ----------------------------------------------------------------------------
// A write transfer stores one breakpoint and gives no result.
// A lookup transfer scans the used entries through the table's one read port,
// one entry per cycle (entries_used capped at the table size), then, for a
// key strictly inside a segment, runs each of the four channels through one
// shared serial divider (multiply, load, 20 divide steps, finish). The core
// takes no new item until the result of a lookup has been taken.
// ----------------------------------------------------------------------------
module piecewise_linear_color_lookup_core
    import plcl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [COUNT_BITS-1:0]  cfg_data,
    // input items
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   cmd,
    input  logic [INDEX_BITS-1:0]  entry_index,
    input  logic [KEY_BITS-1:0]    entry_key,
    input  logic [CHAN_BITS-1:0]   entry_red,
    input  logic [CHAN_BITS-1:0]   entry_green,
    input  logic [CHAN_BITS-1:0]   entry_blue,
    input  logic [CHAN_BITS-1:0]   entry_alpha,
    input  logic [KEY_BITS-1:0]    query_key,
    // results
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CHAN_BITS-1:0]   out_red,
    output logic [CHAN_BITS-1:0]   out_green,
    output logic [CHAN_BITS-1:0]   out_blue,
    output logic [CHAN_BITS-1:0]   out_alpha,
    output logic                   found
);

    state_t                             state_reg, state_next;
    logic [COUNT_BITS-1:0]              entries_reg;
    logic [CNT_BITS-1:0]                n_reg;
    logic [CNT_BITS-1:0]                n_clamp;
    logic [KEY_BITS-1:0]                x_reg;
    logic [CNT_BITS-1:0]                rd_cnt_reg;
    logic                               pend_vld_reg;
    logic [CNT_BITS-1:0]                pend_idx_reg;
    entry_t                             prev_reg;
    match_t                             mode_reg;
    entry_t                             a_reg;
    entry_t                             b_reg;
    logic [CHAN_SEL_BITS-1:0]           chan_reg;
    logic [NUM_CHAN-1:0][CHAN_BITS-1:0] res_reg;
    logic                               found_reg;
    logic [DIVIDEND_BITS-1:0]           prod_reg;
    logic [KEY_BITS-1:0]                den_reg;
    logic                               neg_reg;

    logic       in_xfer, lookup_start, write_en;
    logic       issue, scan_end;
    logic       seg_hit, a_hit, last_hit;
    entry_t     wr_data, rd_data;
    div_req_t   div_req;
    div_resp_t  div_resp;
    logic       div_start;
    logic [31:0]                 index_wide;
    logic [KEY_BITS-1:0]         dx;
    logic [CHAN_BITS-1:0]        y0, y1, mag;
    logic                        y_neg;
    logic [DIVIDEND_BITS-1:0]    prod;
    logic [CHAN_BITS-1:0]        q_lo;
    logic [CHAN_BITS-1:0]        chan_val;

    // handshakes
    assign cfg_ready    = 1'b1;
    assign in_xfer      = in_valid && in_ready;
    assign lookup_start = in_xfer && (cmd == CMD_LOOKUP);
    assign index_wide   = 32'(entry_index);
    assign write_en     = in_xfer && (cmd == CMD_WRITE) && (index_wide < 32'(MAX_ENTRIES));
    assign n_clamp      = (32'(entries_reg) > 32'(MAX_ENTRIES)) ? CNT_BITS'(MAX_ENTRIES)
                                                                 : CNT_BITS'(entries_reg);

    // breakpoint entry assembly
    always_comb
    begin
        wr_data.key     = entry_key;
        wr_data.chan[0] = entry_red;
        wr_data.chan[1] = entry_green;
        wr_data.chan[2] = entry_blue;
        wr_data.chan[3] = entry_alpha;
    end

    plcl_table u_table
    (
        .clk     (clk),
        .wr_en   (write_en),
        .wr_addr (index_wide[ADDR_BITS-1:0]),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (rd_cnt_reg[ADDR_BITS-1:0]),
        .rd_data (rd_data)
    );

    // scan compare: segment of previous and current entry, exact hits
    assign scan_end = (state_reg == ST_SCAN) && !issue && !pend_vld_reg;
    assign seg_hit  = (pend_idx_reg != '0) && (x_reg > prev_reg.key) && (x_reg < rd_data.key);
    assign a_hit    = (pend_idx_reg != '0) && (x_reg == prev_reg.key);
    assign last_hit = (pend_idx_reg == n_reg - CNT_BITS'(1)) && (x_reg == rd_data.key);

    // channel multiply ahead of the divider
    always_comb
    begin
        dx    = x_reg - a_reg.key;
        y0    = a_reg.chan[chan_reg];
        y1    = b_reg.chan[chan_reg];
        y_neg = (y1 < y0);
        mag   = y_neg ? (y0 - y1) : (y1 - y0);
        prod  = DIVIDEND_BITS'(dx) * DIVIDEND_BITS'(mag);
    end

    // floor correction of the quotient on a falling channel
    always_comb
    begin
        q_lo = div_resp.quotient[CHAN_BITS-1:0];
        if (neg_reg)
        begin
            chan_val = y0 - q_lo - CHAN_BITS'(div_resp.rem_nz);
        end
        else
        begin
            chan_val = y0 + q_lo;
        end
    end

    assign div_req.start    = div_start;
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = den_reg;

    plcl_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (lookup_start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    if (mode_reg == MATCH_INTERP)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_resp.done)
                begin
                    if (chan_reg == CHAN_SEL_BITS'(NUM_CHAN - 1))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        issue     = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SCAN:
            begin
                issue = (rd_cnt_reg < n_reg);
            end
            ST_LOAD:
            begin
                div_start = 1'b1;
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            entries_reg  <= ENTRIES_RESET;
            pend_vld_reg <= 1'b0;
            rd_cnt_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_vld_reg <= issue;
            if (cfg_valid && cfg_ready)
            begin
                entries_reg <= cfg_data;
            end
            if (lookup_start)
            begin
                rd_cnt_reg <= '0;
            end
            else if (issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + CNT_BITS'(1);
            end
        end
    end

    // lookup datapath
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_idx_reg <= rd_cnt_reg;
        end
        if (lookup_start)
        begin
            x_reg    <= query_key;
            n_reg    <= n_clamp;
            mode_reg <= MATCH_NONE;
        end
        // last match wins, final-entry exact hit ahead of its segment
        if (pend_vld_reg)
        begin
            prev_reg <= rd_data;
            if (last_hit)
            begin
                mode_reg <= MATCH_EXACT;
                a_reg    <= rd_data;
            end
            else if (seg_hit)
            begin
                mode_reg <= MATCH_INTERP;
                a_reg    <= prev_reg;
                b_reg    <= rd_data;
            end
            else if (a_hit)
            begin
                mode_reg <= MATCH_EXACT;
                a_reg    <= prev_reg;
            end
        end
        if (scan_end)
        begin
            chan_reg <= '0;
            case (mode_reg)
                MATCH_EXACT:
                begin
                    res_reg   <= a_reg.chan;
                    found_reg <= 1'b1;
                end
                MATCH_INTERP:
                begin
                    found_reg <= 1'b1;
                end
                default:
                begin
                    res_reg   <= '0;
                    found_reg <= 1'b0;
                end
            endcase
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod;
            den_reg  <= b_reg.key - a_reg.key;
            neg_reg  <= y_neg;
        end
        if ((state_reg == ST_DIV) && div_resp.done)
        begin
            res_reg[chan_reg] <= chan_val;
            chan_reg          <= chan_reg + CHAN_SEL_BITS'(1);
        end
    end

    assign out_red   = res_reg[0];
    assign out_green = res_reg[1];
    assign out_blue  = res_reg[2];
    assign out_alpha = res_reg[3];
    assign found     = found_reg;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the piecewise linear color lookup core. Breakpoint
// tables of several shapes are loaded, the entry count is stepped through its
// extremes between phases, and lookups aimed at breakpoints, their neighbors
// and segment interiors are checked against an in-bench interpolator.
// ----------------------------------------------------------------------------
module tb_top;
    import plcl_pkg::*;

    localparam int NUM_PHASES        = 10;
    localparam int LOOKUPS_PER_PHASE = 100;
    localparam int SETTLE_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int MAX_REPORTS       = 10;

    // shapes of breakpoint table loaded at the start of a phase
    typedef enum
    {
        SHAPE_SPREAD,
        SHAPE_WIDE,
        SHAPE_ASCEND,
        SHAPE_DENSE,
        SHAPE_SHUFFLED
    } table_shape_t;

    // result port ready patterns
    typedef enum
    {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_CYCLIC,
        READY_SPARSE
    } ready_pattern_t;

    typedef struct packed
    {
        cmd_t                   op;
        logic [INDEX_BITS-1:0]  index;
        entry_t                 entry;
        logic [KEY_BITS-1:0]    query;
    } table_item_t;

    typedef struct packed
    {
        logic [KEY_BITS-1:0]                 query;
        logic [NUM_CHAN-1:0][CHAN_BITS-1:0]  chan;
        logic                                hit;
    } color_due_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [COUNT_BITS-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   cmd = CMD_WRITE;
    logic [INDEX_BITS-1:0]  entry_index = '0;
    logic [KEY_BITS-1:0]    entry_key = '0;
    logic [CHAN_BITS-1:0]   entry_red = '0;
    logic [CHAN_BITS-1:0]   entry_green = '0;
    logic [CHAN_BITS-1:0]   entry_blue = '0;
    logic [CHAN_BITS-1:0]   entry_alpha = '0;
    logic [KEY_BITS-1:0]    query_key = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [CHAN_BITS-1:0]   out_red;
    logic [CHAN_BITS-1:0]   out_green;
    logic [CHAN_BITS-1:0]   out_blue;
    logic [CHAN_BITS-1:0]   out_alpha;
    logic                   found;

    // items waiting for the driver, colors waiting for the core
    table_item_t   pending_items[$];
    color_due_t    colors_due[$];

    // bench copy of the core state
    entry_t                 breakpoints[MAX_ENTRIES];
    logic [COUNT_BITS-1:0]  entries_used_copy = ENTRIES_RESET;

    // stimulus-side view of the keys, used to aim lookups
    int  planned_keys[MAX_ENTRIES];
    int  planned_used = ENTRIES_RESET;

    int  fail_count = 0;
    int  quiet_cycles = 0;

    piecewise_linear_color_lookup_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .entry_index (entry_index),
        .entry_key   (entry_key),
        .entry_red   (entry_red),
        .entry_green (entry_green),
        .entry_blue  (entry_blue),
        .entry_alpha (entry_alpha),
        .query_key   (query_key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .out_alpha   (out_alpha),
        .found       (found)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // one channel inside a segment, quotient rounded toward minus infinity
    function automatic logic [CHAN_BITS-1:0] blend_channel(int x, int x0, int x1,
                                                           int y0, int y1);
        int num;
        int den;
        int q;
        num = (x - x0) * (y1 - y0);
        den = x1 - x0;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return CHAN_BITS'(y0 + q);
    endfunction

    // color expected for a query against the current table copy
    function automatic color_due_t predict_color(logic [KEY_BITS-1:0] qk);
        color_due_t r;
        entry_t lo_e;
        entry_t hi_e;
        int n;
        int x;
        int i;
        int c;
        n = (entries_used_copy > MAX_ENTRIES) ? MAX_ENTRIES : int'(entries_used_copy);
        x = qk;
        r = '0;
        r.query = qk;
        for (i = 0; i + 1 < n; i++)
        begin
            lo_e = breakpoints[i];
            hi_e = breakpoints[i + 1];
            if (x > int'(lo_e.key) && x < int'(hi_e.key))
            begin
                for (c = 0; c < NUM_CHAN; c++)
                    r.chan[c] = blend_channel(x, lo_e.key, hi_e.key,
                                              lo_e.chan[c], hi_e.chan[c]);
                r.hit = 1'b1;
            end
            else if (x == int'(lo_e.key))
            begin
                r.chan = lo_e.chan;
                r.hit = 1'b1;
            end
        end
        // last used breakpoint matches on its exact key
        if (n >= 1 && x == int'(breakpoints[n - 1].key))
        begin
            r.chan = breakpoints[n - 1].chan;
            r.hit = 1'b1;
        end
        return r;
    endfunction

    function automatic entry_t random_entry();
        entry_t e;
        int c;
        e.key = KEY_BITS'($urandom_range(0, 4095));
        for (c = 0; c < NUM_CHAN; c++)
        begin
            if ($urandom_range(0, 7) == 0)
                e.chan[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                e.chan[c] = CHAN_BITS'($urandom);
        end
        return e;
    endfunction

    task automatic queue_write(int idx, entry_t e);
        table_item_t it;
        it.op = CMD_WRITE;
        it.index = INDEX_BITS'(idx);
        it.entry = e;
        it.query = KEY_BITS'($urandom_range(0, 4095));
        planned_keys[idx] = e.key;
        pending_items.push_back(it);
    endtask

    task automatic queue_lookup(int qk);
        table_item_t it;
        it.op = CMD_LOOKUP;
        it.index = INDEX_BITS'($urandom_range(0, MAX_ENTRIES - 1));
        it.entry = random_entry();
        it.query = KEY_BITS'(qk);
        pending_items.push_back(it);
    endtask

    // rewrite all entries so no lookup ever touches an unwritten one
    task automatic load_breakpoints(table_shape_t shape);
        entry_t e;
        int i;
        int k;
        k = (shape == SHAPE_DENSE) ? $urandom_range(0, 3800) : $urandom_range(0, 30);
        for (i = 0; i < MAX_ENTRIES; i++)
        begin
            e = random_entry();
            case (shape)
                SHAPE_SPREAD:   e.key = KEY_BITS'(i * 65);
                SHAPE_WIDE:     if (i < 2) e.key = (i == 0) ? '0 : '1;
                SHAPE_ASCEND:   e.key = KEY_BITS'((k > 4095) ? 4095 : k);
                SHAPE_DENSE:    e.key = KEY_BITS'((k > 4095) ? 4095 : k);
                default:        ;
            endcase
            // steepest rising and falling slopes on the first segment
            if ((shape == SHAPE_SPREAD || shape == SHAPE_WIDE) && i < 2)
                e.chan = (i == 0) ? {8'hFF, 8'h00, 8'hFF, 8'h00}
                                  : {8'h00, 8'hFF, 8'h00, 8'hFF};
            k = k + ((shape == SHAPE_DENSE) ? $urandom_range(0, 3) : $urandom_range(1, 60));
            queue_write(i, e);
        end
    endtask

    // lookup key near breakpoints, inside the used span, or anywhere
    function automatic int aim_query();
        int n;
        int i;
        int lo;
        int hi;
        n = (planned_used > MAX_ENTRIES) ? MAX_ENTRIES : planned_used;
        if (n == 0)
            return $urandom_range(0, 4095);
        i = $urandom_range(0, n - 1);
        lo = planned_keys[0];
        hi = planned_keys[n - 1];
        case ($urandom_range(0, 9))
            0, 1, 2:    return planned_keys[i];
            3:          return (planned_keys[i] + 1) % 4096;
            4:          return (planned_keys[i] + 4095) % 4096;
            5, 6, 7, 8: return (lo < hi) ? $urandom_range(lo, hi) : $urandom_range(0, 4095);
            default:    return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic logic [COUNT_BITS-1:0] phase_setting(int phase);
        case (phase)
            1:          return COUNT_BITS'(64);
            2:          return COUNT_BITS'(2);
            3:          return COUNT_BITS'(0);
            4:          return COUNT_BITS'(1);
            5:          return COUNT_BITS'(127);
            6:          return COUNT_BITS'(65);
            7:          return COUNT_BITS'(63);
            8:          return COUNT_BITS'($urandom_range(2, 64));
            default:    return COUNT_BITS'($urandom_range(0, 127));
        endcase
    endfunction

    // wait until every item is in and every color is out
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || colors_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // stimulus sequencing and entry count writes
    initial
    begin
        int phase;
        int n;
        int idx;
        table_shape_t shape;
        entry_t e;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                wait_drained();
                @(posedge clk);
                cfg_valid <= 1'b1;
                cfg_data <= phase_setting(phase);
                do @(posedge clk); while (!cfg_ready);
                cfg_valid <= 1'b0;
                planned_used = cfg_data;
                @(negedge clk);
            end
            if (phase == 0)
                shape = SHAPE_SPREAD;
            else if (planned_used == 2)
                shape = SHAPE_WIDE;
            else
            begin
                case ($urandom_range(0, 9))
                    0:          shape = SHAPE_SHUFFLED;
                    1:          shape = SHAPE_DENSE;
                    2:          shape = SHAPE_SPREAD;
                    default:    shape = SHAPE_ASCEND;
                endcase
            end
            load_breakpoints(shape);
            // first phase: breakpoint hits, segment edges, last entry, misses
            if (phase == 0)
            begin
                queue_lookup(0);
                queue_lookup(1);
                queue_lookup(32);
                queue_lookup(64);
                queue_lookup(65);
                queue_lookup(66);
                queue_lookup(1300);
                queue_lookup(2534);
                queue_lookup(2535);
                queue_lookup(2536);
                queue_lookup(4094);
                queue_lookup(4095);
            end
            for (n = 0; n < LOOKUPS_PER_PHASE; n++)
            begin
                // occasional stray write that may break key order
                if ($urandom_range(0, 11) == 0)
                begin
                    idx = $urandom_range(0, MAX_ENTRIES - 1);
                    e = random_entry();
                    queue_write(idx, e);
                end
                queue_lookup(aim_query());
            end
        end
        wait_drained();
        if (fail_count == 0 && colors_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // input driver: bursts of items with random gaps
    int           burst_left = 1;
    int           gap_left = 0;
    table_item_t  drive_item;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0 || pending_items.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                in_valid <= 1'b0;
            end
            else
            begin
                drive_item = pending_items.pop_front();
                in_valid <= 1'b1;
                cmd <= drive_item.op;
                entry_index <= drive_item.index;
                entry_key <= drive_item.entry.key;
                entry_red <= drive_item.entry.chan[0];
                entry_green <= drive_item.entry.chan[1];
                entry_blue <= drive_item.entry.chan[2];
                entry_alpha <= drive_item.entry.chan[3];
                query_key <= drive_item.query;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 2) == 0)
                        gap_left = 0;
                    else if ($urandom_range(0, 9) == 0)
                        gap_left = $urandom_range(10, 40);
                    else
                        gap_left = $urandom_range(1, 5);
                end
            end
        end
    end

    // result receiver: randomly chosen ready patterns
    int              ready_tick = 0;
    ready_pattern_t  ready_pattern = READY_ALWAYS;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            ready_tick++;
            if (ready_tick % 300 == 0)
                ready_pattern = ready_pattern_t'($urandom_range(0, 3));
            case (ready_pattern)
                READY_ALWAYS:   out_ready <= 1'b1;
                READY_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
                READY_CYCLIC:   out_ready <= ((ready_tick % 7) < 3);
                default:        out_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // monitor: check colors, track writes and entry count, feed the watchdog
    color_due_t  want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // result transfer
            if (out_valid && out_ready)
            begin
                if (colors_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: r=%0d g=%0d b=%0d a=%0d found=%0d",
                                 out_red, out_green, out_blue, out_alpha, found);
                end
                else
                begin
                    want = colors_due.pop_front();
                    if (out_red !== want.chan[0] || out_green !== want.chan[1] ||
                        out_blue !== want.chan[2] || out_alpha !== want.chan[3] ||
                        found !== want.hit)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("key %0d: expected r=%0d g=%0d b=%0d a=%0d found=%0d",
                                     want.query, want.chan[0], want.chan[1], want.chan[2],
                                     want.chan[3], want.hit);
                            $display("key %0d: got r=%0d g=%0d b=%0d a=%0d found=%0d",
                                     want.query, out_red, out_green, out_blue,
                                     out_alpha, found);
                        end
                    end
                end
            end
            // input transfer
            if (in_valid && in_ready)
            begin
                if (cmd == CMD_LOOKUP)
                begin
                    colors_due.push_back(predict_color(query_key));
                end
                else
                begin
                    breakpoints[entry_index].key = entry_key;
                    breakpoints[entry_index].chan[0] = entry_red;
                    breakpoints[entry_index].chan[1] = entry_green;
                    breakpoints[entry_index].chan[2] = entry_blue;
                    breakpoints[entry_index].chan[3] = entry_alpha;
                end
            end
            // entry count write
            if (cfg_valid && cfg_ready)
                entries_used_copy = cfg_data;
            if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/plcl_pkg.sv
rtl/core/plcl_table.sv
rtl/core/plcl_div.sv
rtl/core/piecewise_linear_color_lookup_core.sv
test/tb_top.sv
